FILE: hw/rtl/snm_pkg.sv
// Shared types and constants for the sine note mixer.
// Used by snm_ctrl, snm_datapath and sine_note_mixer_top; depends on nothing.
package snm_pkg;

   // Default sizes for the top-level parameters
   localparam int NOTE_SLOTS_DEF     = 64;
   localparam int SINE_ADDR_BITS_DEF = 10;

   // Fixed field widths
   localparam int SLOT_FIELD_W = 6;
   localparam int TIME_W       = 24;
   localparam int STEP_W       = 32;
   localparam int GAIN_W       = 16;
   localparam int USE_W        = 7;
   localparam int MIX_W        = 24;
   localparam int SINE_W       = 15;   // magnitude of a quarter-wave entry

   // Request kinds
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // Register file
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;
   localparam logic [CSR_INDEX_W-1:0] CSR_NOTES_IN_USE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LENGTH_LIMIT = 2'd1;
   localparam logic [TIME_W-1:0]      LENGTH_LIMIT_RST = 24'hFFFFFF;

   // Output clip bounds
   localparam logic signed [MIX_W-1:0] MIX_MAX = 24'sh7FFFFF;
   localparam logic signed [MIX_W-1:0] MIX_MIN = -24'sh800000;

   // One stored note
   typedef struct packed {
      logic [TIME_W-1:0] start;
      logic [TIME_W-1:0] length;
      logic [STEP_W-1:0] step;
      logic [GAIN_W-1:0] gain;
   } snm_note_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_ROUND,
      ST_PUBLISH
   } snm_state_type;

   // Controller to datapath
   typedef struct packed {
      logic load_en;     // write the requested note slot
      logic tick_start;  // clear accumulator and slot counter
      logic scan_step;   // read the next slot into the pipeline
      logic round_en;    // scale the finished sum
      logic publish;     // load the output register, advance the clock
   } snm_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic tick_live;   // sample clock below the length limit
      logic scan_done;   // every slot in use has been issued
      logic pipe_empty;  // no slot left in flight
      logic out_busy;    // output register full and not taken this cycle
   } snm_status_type;

endpackage

FILE: hw/rtl/snm_ctrl.sv
// Sequencing state machine of the sine note mixer.
// Depends on snm_pkg for the state, command and status types.
module snm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_kind,
   input  snm_pkg::snm_status_type status,
   output snm_pkg::snm_cmd_type    cmd
);
   import snm_pkg::*;

   snm_state_type state_ff, state_in;

   // Hold the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_kind == KIND_TICK && status.tick_live) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (status.pipe_empty) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            state_in = ST_PUBLISH;
         end
         ST_PUBLISH: begin
            if (!status.out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Commands and handshake
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready      = 1'b1;
            cmd.load_en    = req_valid && (req_kind == KIND_LOAD);
            cmd.tick_start = req_valid && (req_kind == KIND_TICK) && status.tick_live;
         end
         ST_SCAN: begin
            cmd.scan_step = !status.scan_done;
         end
         ST_DRAIN: begin
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
         end
         ST_PUBLISH: begin
            cmd.publish = !status.out_busy;
         end
         default: begin
         end
      endcase
   end

endmodule

FILE: hw/rtl/snm_datapath.sv
// Note memories, sine pipeline, accumulator, registers and output stage.
// Depends on snm_pkg; driven by snm_ctrl through command and status structs.
module snm_datapath #(
   parameter int NOTE_SLOTS     = snm_pkg::NOTE_SLOTS_DEF,
   parameter int SINE_ADDR_BITS = snm_pkg::SINE_ADDR_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  snm_pkg::snm_cmd_type                   cmd,
   output snm_pkg::snm_status_type                status,
   input  logic [snm_pkg::SLOT_FIELD_W-1:0]       req_slot,
   input  logic [snm_pkg::TIME_W-1:0]             req_start_sample,
   input  logic [snm_pkg::TIME_W-1:0]             req_length_samples,
   input  logic [snm_pkg::STEP_W-1:0]             req_phase_step,
   input  logic [snm_pkg::GAIN_W-1:0]             req_amplitude,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [snm_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [snm_pkg::CSR_DATA_W-1:0]         csr_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [snm_pkg::MIX_W-1:0]       rsp_mixed_sample,
   output logic [snm_pkg::TIME_W-1:0]             rsp_sample_index,
   output logic                                   rsp_saturated
);
   import snm_pkg::*;

   localparam int SLOT_W     = (NOTE_SLOTS > 1) ? $clog2(NOTE_SLOTS) : 1;
   localparam int CNT_W      = $clog2(NOTE_SLOTS + 1);
   localparam int SLOT_EXT_W = (SLOT_W > SLOT_FIELD_W) ? SLOT_W : SLOT_FIELD_W;
   localparam int QTR_W      = SINE_ADDR_BITS - 2;
   localparam int QTR_LEN    = 1 << QTR_W;
   localparam int PROD_W     = GAIN_W + SINE_W + 2;
   localparam int ACC_W      = PROD_W + CNT_W;
   localparam int ROUND_SH   = 14;

   localparam logic [63:0]             HALF_PI_Q30 = 64'd1686629713;
   localparam logic signed [ACC_W-1:0] ROUND_HALF  = ACC_W'(8192);
   localparam logic signed [ACC_W-1:0] CLIP_HI     = ACC_W'(MIX_MAX);
   localparam logic signed [ACC_W-1:0] CLIP_LO     = ACC_W'(MIX_MIN);

   typedef logic [SINE_W-1:0] qw_rom_type [QTR_LEN];

   // Quarter-wave entry q: Taylor series of sin to x^13 in Q30, rounded to Q15
   function automatic logic [SINE_W-1:0] sine_entry(input int q);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        r;
      x    = (HALF_PI_Q30 * 64'(2 * q + 1)) >> (SINE_ADDR_BITS - 1);
      x2   = (x * x) >> 30;
      term = x;
      sum  = signed'(x);
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + signed'(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + signed'(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + signed'(term);
      if (sum < 0) begin
         sum = '0;
      end
      r = (64'(sum) + 64'd16384) >> 15;
      if (r > 64'd32767) begin
         r = 64'd32767;
      end
      return r[SINE_W-1:0];
   endfunction

   function automatic qw_rom_type build_qw_rom();
      qw_rom_type t;
      for (int q = 0; q < QTR_LEN; q++) begin
         t[q] = sine_entry(q);
      end
      return t;
   endfunction

   localparam qw_rom_type QW_ROM = build_qw_rom();

   // Storage; phase of a slot is zeroed by its load, so the phase memory needs
   // no clearing pass if the user mixes only loaded slots, which is not enforced
   snm_note_type      note_mem  [NOTE_SLOTS];
   logic [STEP_W-1:0] phase_mem [NOTE_SLOTS];

   logic [USE_W-1:0]  notes_in_use_ff;
   logic [TIME_W-1:0] length_limit_ff;
   logic [TIME_W-1:0] clock_ff;
   logic [CNT_W-1:0]  scan_ff;
   logic [CNT_W-1:0]  used;

   logic [SLOT_EXT_W-1:0] slot_ext;
   logic [SLOT_W-1:0]     load_addr;
   logic                  slot_ok;
   logic [SLOT_W-1:0]     scan_addr;

   // Pipeline registers
   logic                     s1_valid_ff;
   logic [SLOT_W-1:0]        s1_slot_ff;
   snm_note_type             s1_note_ff;
   logic [STEP_W-1:0]        s1_phase_ff;
   logic                     s1_cover;
   logic                     phase_wr;
   logic [SINE_ADDR_BITS-1:0] sine_idx;
   logic [QTR_W-1:0]         q_sel;

   logic                     s2_valid_ff;
   logic                     s2_cov_ff;
   logic                     s2_neg_ff;
   logic [GAIN_W-1:0]        s2_gain_ff;
   logic [SINE_W-1:0]        rom_ff;
   logic signed [SINE_W:0]   sine_val;
   logic signed [GAIN_W:0]   gain_val;
   logic signed [PROD_W-1:0] prod_in;

   logic                     s3_valid_ff;
   logic signed [PROD_W-1:0] s3_prod_ff;

   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  rnd_ff;

   logic                     rsp_valid_ff;
   logic signed [MIX_W-1:0]  rsp_mixed_ff;
   logic [TIME_W-1:0]        rsp_index_ff;
   logic                     rsp_sat_ff;
   logic signed [MIX_W-1:0]  clip_val;
   logic                     clip_sat;

   // Register writes; the port never stalls
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         notes_in_use_ff <= '0;
         length_limit_ff <= LENGTH_LIMIT_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_NOTES_IN_USE: notes_in_use_ff <= csr_data[USE_W-1:0];
            CSR_LENGTH_LIMIT: length_limit_ff <= csr_data[TIME_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Clamp slots in use to the table depth
   always_comb begin
      if (int'(notes_in_use_ff) > NOTE_SLOTS) begin
         used = CNT_W'(NOTE_SLOTS);
      end else begin
         used = CNT_W'(notes_in_use_ff);
      end
   end

   // Load address; drop loads beyond the table
   assign slot_ext  = SLOT_EXT_W'(req_slot);
   assign load_addr = slot_ext[SLOT_W-1:0];
   assign slot_ok   = (32'(req_slot) < NOTE_SLOTS);
   assign scan_addr = scan_ff[SLOT_W-1:0];

   // Note memory write port
   always_ff @(posedge clock) begin
      if (cmd.load_en && slot_ok) begin
         note_mem[load_addr] <= '{start:  req_start_sample,
                                  length: req_length_samples,
                                  step:   req_phase_step,
                                  gain:   req_amplitude};
      end
   end

   // Phase memory write port: zero on load, advance on a covered slot
   always_ff @(posedge clock) begin
      if (cmd.load_en && slot_ok) begin
         phase_mem[load_addr] <= '0;
      end else if (phase_wr) begin
         phase_mem[s1_slot_ff] <= s1_phase_ff + s1_note_ff.step;
      end
   end

   // Slot counter
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= '0;
      end else if (cmd.tick_start) begin
         scan_ff <= '0;
      end else if (cmd.scan_step) begin
         scan_ff <= scan_ff + CNT_W'(1);
      end
   end

   // Issue: registered memory reads
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.scan_step;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_step) begin
         s1_note_ff  <= note_mem[scan_addr];
         s1_phase_ff <= phase_mem[scan_addr];
         s1_slot_ff  <= scan_addr;
      end
   end

   // Coverage test and quarter-wave address
   assign s1_cover = (clock_ff >= s1_note_ff.start) &&
                     ((clock_ff - s1_note_ff.start) < s1_note_ff.length);
   assign phase_wr = s1_valid_ff && s1_cover;
   assign sine_idx = s1_phase_ff[STEP_W-1 -: SINE_ADDR_BITS];
   assign q_sel    = sine_idx[SINE_ADDR_BITS-2] ? ~sine_idx[QTR_W-1:0]
                                                : sine_idx[QTR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rom_ff     <= QW_ROM[q_sel];
      s2_cov_ff  <= s1_cover;
      s2_neg_ff  <= sine_idx[SINE_ADDR_BITS-1];
      s2_gain_ff <= s1_note_ff.gain;
   end

   // Sign the sine and weight it by the gain at full product width
   assign sine_val = s2_neg_ff ? -signed'({1'b0, rom_ff}) : signed'({1'b0, rom_ff});
   assign gain_val = signed'({1'b0, s2_gain_ff});
   assign prod_in  = s2_cov_ff ? (PROD_W'(gain_val) * PROD_W'(sine_val)) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_prod_ff <= prod_in;
   end

   // Accumulate the weighted sines
   always_ff @(posedge clock) begin
      if (cmd.tick_start) begin
         acc_ff <= '0;
      end else if (s3_valid_ff) begin
         acc_ff <= acc_ff + {{CNT_W{s3_prod_ff[PROD_W-1]}}, s3_prod_ff};
      end
   end

   // Scale Q3.29 to Q8.15, rounding half up
   always_ff @(posedge clock) begin
      if (cmd.round_en) begin
         rnd_ff <= (acc_ff + ROUND_HALF) >>> ROUND_SH;
      end
   end

   // Clip to the output range
   always_comb begin
      clip_sat = 1'b0;
      clip_val = rnd_ff[MIX_W-1:0];
      if (rnd_ff > CLIP_HI) begin
         clip_val = MIX_MAX;
         clip_sat = 1'b1;
      end else if (rnd_ff < CLIP_LO) begin
         clip_val = MIX_MIN;
         clip_sat = 1'b1;
      end
   end

   // Sample clock
   always_ff @(posedge clock) begin
      if (reset) begin
         clock_ff <= '0;
      end else if (cmd.publish) begin
         clock_ff <= clock_ff + TIME_W'(1);
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_mixed_ff <= clip_val;
         rsp_index_ff <= clock_ff;
         rsp_sat_ff   <= clip_sat;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mixed_sample = rsp_mixed_ff;
   assign rsp_sample_index = rsp_index_ff;
   assign rsp_saturated    = rsp_sat_ff;

   // Status back to the controller
   assign status.tick_live  = (clock_ff < length_limit_ff);
   assign status.scan_done  = (scan_ff == used);
   assign status.pipe_empty = !s1_valid_ff && !s2_valid_ff && !s3_valid_ff;
   assign status.out_busy   = rsp_valid_ff && !rsp_ready;

`ifndef SYNTHESIS
   // A load never lands while a slot is in flight
   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load_en && !status.pipe_empty))
      else $error("note load while pipeline busy");

   // A new transaction only starts on an empty pipeline
   a_start_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.tick_start |=> !s2_valid_ff && !s3_valid_ff)
      else $error("tick started over slots in flight");

   // The sample clock moves only when a result is published
   a_clock_moves: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && clock_ff != $past(clock_ff)) |-> $past(cmd.publish))
      else $error("sample clock moved without a result");

   // A clipped result sits at a bound
   a_sat_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_sat_ff) |->
         (rsp_mixed_ff == MIX_MAX || rsp_mixed_ff == MIX_MIN))
      else $error("saturation flag off a bound");
`endif

endmodule

FILE: hw/rtl/sine_note_mixer_top.sv
// Top level of the sine note mixer: additive sine synthesis over a note table.
// Depends on snm_pkg, snm_ctrl and snm_datapath.
//
//   channel  direction  handshake              payload
//   req_     in         req_valid / req_ready  kind, slot, start, length, step, amplitude
//   rsp_     out        rsp_valid / rsp_ready  mixed_sample, sample_index, saturated
//   csr_     in         csr_valid / csr_ready  index, data
//
// A load is written in the idle state. A tick at or past the length limit is
// taken with no result. A live tick makes one memory read per slot in use
// (notes_in_use capped at NOTE_SLOTS), ends the scan, drains the three-stage
// sine and multiply pipeline, rounds the sum and publishes it. Reset clears
// control state, the sample clock and the registers; no clearing pass runs.
// A stalled result waits in the output register; the block goes on with loads
// and finishes the next tick's sum, holding it only until the output register
// frees up.
module sine_note_mixer_top #(
   parameter int NOTE_SLOTS     = snm_pkg::NOTE_SLOTS_DEF,
   parameter int SINE_ADDR_BITS = snm_pkg::SINE_ADDR_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_kind,
   input  logic [snm_pkg::SLOT_FIELD_W-1:0]  req_slot,
   input  logic [snm_pkg::TIME_W-1:0]        req_start_sample,
   input  logic [snm_pkg::TIME_W-1:0]        req_length_samples,
   input  logic [snm_pkg::STEP_W-1:0]        req_phase_step,
   input  logic [snm_pkg::GAIN_W-1:0]        req_amplitude,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [snm_pkg::MIX_W-1:0]  rsp_mixed_sample,
   output logic [snm_pkg::TIME_W-1:0]        rsp_sample_index,
   output logic                              rsp_saturated,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [snm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [snm_pkg::CSR_DATA_W-1:0]    csr_data
);
   import snm_pkg::*;

   snm_cmd_type    cmd;
   snm_status_type status;

   // Sequencing
   snm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .status    (status),
      .cmd       (cmd)
   );

   // Storage and arithmetic
   snm_datapath #(
      .NOTE_SLOTS     (NOTE_SLOTS),
      .SINE_ADDR_BITS (SINE_ADDR_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_slot           (req_slot),
      .req_start_sample   (req_start_sample),
      .req_length_samples (req_length_samples),
      .req_phase_step     (req_phase_step),
      .req_amplitude      (req_amplitude),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_mixed_sample   (rsp_mixed_sample),
      .rsp_sample_index   (rsp_sample_index),
      .rsp_saturated      (rsp_saturated)
   );

endmodule
